### rtl/bfsa_pkg.sv
// shared types and constants of the bitmap free space allocator
// no dependencies; imported by every module of the block
package bfsa_pkg;

   // fixed field widths of the request and response
   localparam int OP_WIDTH    = 2;
   localparam int INDEX_WIDTH = 10;
   localparam int COUNT_WIDTH = 11;

   // default configuration of the map
   localparam int DEF_MAP_BITS   = 1024;
   localparam int DEF_WORD_BITS  = 32;
   localparam int DEF_PRESET_BIT = 0;

   // request operation codes
   typedef enum logic [OP_WIDTH-1:0] {
      OP_SET   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_TEST  = 2'd2,
      OP_FIND  = 2'd3
   } op_type;

   // response status codes
   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_NO_FREE = 1'b1;

   // update of one full flag after a word is rewritten
   typedef struct packed {
      logic write;
      logic full;
   } flag_upd_type;

endpackage

### rtl/bfsa_word_mem.sv
// single port write, single port read synchronous word memory
// read data is registered and holds while no read is issued; uses bfsa_pkg
module bfsa_word_mem #(
   parameter int DEPTH = bfsa_pkg::DEF_MAP_BITS / bfsa_pkg::DEF_WORD_BITS,
   parameter int WIDTH = bfsa_pkg::DEF_WORD_BITS,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);
   import bfsa_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bfsa_full_flags.sv
// per word full flags and the encoder for the lowest word with a free bit
// uses bfsa_pkg for the flag update struct
module bfsa_full_flags #(
   parameter int NUM_WORDS   = bfsa_pkg::DEF_MAP_BITS / bfsa_pkg::DEF_WORD_BITS,
   parameter int AW          = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
   parameter int PRESET_WORD = 0,
   parameter bit PRESET_FULL = 1'b0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bfsa_pkg::flag_upd_type upd,
   input  logic [AW-1:0]          upd_addr,
   output logic [AW-1:0]          first_free_addr,
   output logic                   any_free
);
   import bfsa_pkg::*;

   // flags after reset: only the preset word may start full
   localparam logic [NUM_WORDS-1:0] RESET_FLAGS = NUM_WORDS'(PRESET_FULL) << PRESET_WORD;

   logic [NUM_WORDS-1:0] flags_ff;
   logic [NUM_WORDS-1:0] flags_in;

   // flag update after a word is rewritten
   always_comb begin
      flags_in = flags_ff;
      if (upd.write) begin
         flags_in[upd_addr] = upd.full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= RESET_FLAGS;
      end else begin
         flags_ff <= flags_in;
      end
   end

   // lowest word whose flag is clear
   always_comb begin
      first_free_addr = '0;
      for (int i = NUM_WORDS - 1; i >= 0; i--) begin
         if (!flags_ff[i]) begin
            first_free_addr = AW'(i);
         end
      end
      any_free = !(&flags_ff);
   end

endmodule

### rtl/bitmap_free_space_allocator.sv
// top level of the bitmap free space allocator: control, word datapath, counts
// depends on bfsa_pkg, bfsa_word_mem and bfsa_full_flags
//
// usage
//   request channel req_*: operation (set, clear, test, find lowest free) and
//   bit position; a transfer happens when req_valid and req_ready are both high.
//   response channel rsp_*: status, bit_value, free_index, used_count and
//   free_count, one response per request, in request order.
// timing
//   the request's map word is read from memory in the transfer cycle and
//   modified and written back in the modify step, which also loads the
//   response register; the next request is taken only after that step.
//   the pace is set by the read-modify-write of one word through the
//   memory and its registered read port; one request is in flight.
//   find uses the per word full flags to pick the word in the transfer cycle.
// reset
//   after reset a clearing pass writes every map word, one word a cycle,
//   with req_ready low; the preset bit, if in the map, is left set and the
//   used count starts at one, else at zero.
// stall
//   the response register holds while rsp_ready is low; a request that
//   finishes then waits in the modify step and the next request is not taken.
module bitmap_free_space_allocator #(
   parameter int MAP_BITS   = bfsa_pkg::DEF_MAP_BITS,
   parameter int WORD_BITS  = bfsa_pkg::DEF_WORD_BITS,
   parameter int PRESET_BIT = bfsa_pkg::DEF_PRESET_BIT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [bfsa_pkg::OP_WIDTH-1:0]    req_operation,
   input  logic [bfsa_pkg::INDEX_WIDTH-1:0] req_bit_pos,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_status,
   output logic                             rsp_bit_value,
   output logic [bfsa_pkg::INDEX_WIDTH-1:0] rsp_free_index,
   output logic [bfsa_pkg::COUNT_WIDTH-1:0] rsp_used_count,
   output logic [bfsa_pkg::COUNT_WIDTH-1:0] rsp_free_count
);
   import bfsa_pkg::*;

   // map geometry
   localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int LOG_W     = $clog2(WORD_BITS);
   localparam int UW        = $clog2(MAP_BITS + 1);
   localparam int LAST_BITS = MAP_BITS - (NUM_WORDS - 1) * WORD_BITS;
   localparam logic [WORD_BITS-1:0] LAST_MASK =
      {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);
   localparam bit ALL_IN_MAP = MAP_BITS >= (2 ** INDEX_WIDTH);

   // preset reserved bit
   localparam bit PRESET_IN_MAP = PRESET_BIT < MAP_BITS;
   localparam int PRESET_WORD   = PRESET_IN_MAP ? PRESET_BIT / WORD_BITS : 0;
   localparam int PRESET_OFS    = PRESET_BIT % WORD_BITS;
   localparam logic [WORD_BITS-1:0] PRESET_VAL = WORD_BITS'(1) << PRESET_OFS;
   localparam bit PRESET_FULL = PRESET_IN_MAP && (PRESET_WORD == NUM_WORDS - 1)
                                && (LAST_BITS == 1);

   // reciprocal for the word index: exact floor for any 10 bit index
   localparam int SHIFT  = INDEX_WIDTH + LOG_W;
   localparam int PROD_W = SHIFT + INDEX_WIDTH;
   localparam logic [PROD_W-1:0] RECIP =
      PROD_W'(((64'd1 << SHIFT) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MODIFY
   } state_type;

   state_type            state_ff;
   logic [AW-1:0]        clr_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_status_ff;
   logic                 rsp_bit_value_ff;
   logic [INDEX_WIDTH-1:0] rsp_free_index_ff;
   logic [COUNT_WIDTH-1:0] rsp_used_count_ff;
   logic [COUNT_WIDTH-1:0] rsp_free_count_ff;

   // request context held over the modify step
   op_type               op_ff;
   logic [INDEX_WIDTH-1:0] idx_ff;
   logic [INDEX_WIDTH-1:0] quot_ff;
   logic [AW-1:0]        word_ff;
   logic                 in_map_ff;
   logic                 hit_ff;
   logic [UW-1:0]        used_ff;
   logic [UW-1:0]        used_in;

   logic                 accept;
   logic                 adv;
   op_type               req_op;
   logic [PROD_W-1:0]    prod;
   logic [INDEX_WIDTH-1:0] quot_in;
   logic [AW-1:0]        word_in;
   logic                 in_map_in;
   logic [AW-1:0]        first_free_addr;
   logic                 any_free;

   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   logic [WORD_BITS-1:0] mem_wr_data;
   logic [WORD_BITS-1:0] rd_data;

   logic [INDEX_WIDTH-1:0] rem_full;
   logic [LOG_W-1:0]     ofs;
   logic [WORD_BITS-1:0] bit_vec;
   logic [WORD_BITS-1:0] word_mask;
   logic [WORD_BITS-1:0] new_word;
   logic [WORD_BITS-1:0] free_bits;
   logic [LOG_W-1:0]     free_pos;
   logic                 old_val;
   logic                 do_bit;
   logic [INDEX_WIDTH-1:0] found;
   flag_upd_type         flag_upd;

   // handshake
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign adv       = (state_ff == ST_MODIFY) && (!rsp_valid_ff || rsp_ready);
   assign req_op    = op_type'(req_operation);

   // word selection in the transfer cycle
   assign prod      = PROD_W'(req_bit_pos) * RECIP;
   assign quot_in   = prod[SHIFT +: INDEX_WIDTH];
   assign in_map_in = ALL_IN_MAP || (req_bit_pos < INDEX_WIDTH'(MAP_BITS));
   assign word_in   = (req_op == OP_FIND) ? first_free_addr : AW'(quot_in);

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_op;
         idx_ff    <= req_bit_pos;
         quot_ff   <= quot_in;
         word_ff   <= word_in;
         in_map_ff <= in_map_in;
         hit_ff    <= any_free;
      end
   end

   // modify step: bit offset, new word and lowest free bit
   always_comb begin
      rem_full  = idx_ff - quot_ff * INDEX_WIDTH'(WORD_BITS);
      ofs       = rem_full[LOG_W-1:0];
      bit_vec   = WORD_BITS'(1) << ofs;
      old_val   = |(rd_data & bit_vec);
      word_mask = (word_ff == AW'(NUM_WORDS - 1)) ? LAST_MASK : {WORD_BITS{1'b1}};
      do_bit    = in_map_ff && (op_ff != OP_FIND);
      case (op_ff)
         OP_SET:   new_word = rd_data | bit_vec;
         OP_CLEAR: new_word = rd_data & ~bit_vec;
         default:  new_word = rd_data;
      endcase
      free_bits = ~rd_data & word_mask;
      free_pos  = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            free_pos = LOG_W'(i);
         end
      end
      found = INDEX_WIDTH'(word_ff) * INDEX_WIDTH'(WORD_BITS) + INDEX_WIDTH'(free_pos);
   end

   // used count changes only when a bit flips
   always_comb begin
      used_in = used_ff;
      if (do_bit && (op_ff == OP_SET) && !old_val) begin
         used_in = used_ff + UW'(1);
      end else if (do_bit && (op_ff == OP_CLEAR) && old_val) begin
         used_in = used_ff - UW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= UW'(PRESET_IN_MAP);
      end else if (adv) begin
         used_ff <= used_in;
      end
   end

   // memory write: clearing pass or write back
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_ff;
         mem_wr_data = (PRESET_IN_MAP && (clr_ff == AW'(PRESET_WORD))) ? PRESET_VAL : '0;
      end else begin
         mem_wr_en   = adv && do_bit && ((op_ff == OP_SET) || (op_ff == OP_CLEAR));
         mem_wr_addr = word_ff;
         mem_wr_data = new_word;
      end
   end

   assign flag_upd.write = adv && do_bit;
   assign flag_upd.full  = ((new_word & word_mask) == word_mask);

   // state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(NUM_WORDS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_MODIFY;
               end
            end
            ST_MODIFY: begin
               if (adv) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         if (adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (adv) begin
         rsp_status_ff     <= ((op_ff == OP_FIND) && !hit_ff) ? STATUS_NO_FREE : STATUS_DONE;
         rsp_bit_value_ff  <= do_bit && old_val;
         rsp_free_index_ff <= ((op_ff == OP_FIND) && hit_ff) ? found : '0;
         rsp_used_count_ff <= COUNT_WIDTH'(used_in);
         rsp_free_count_ff <= COUNT_WIDTH'(UW'(MAP_BITS) - used_in);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_bit_value  = rsp_bit_value_ff;
   assign rsp_free_index = rsp_free_index_ff;
   assign rsp_used_count = rsp_used_count_ff;
   assign rsp_free_count = rsp_free_count_ff;

   bfsa_word_mem #(
      .DEPTH (NUM_WORDS),
      .WIDTH (WORD_BITS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (word_in),
      .rd_data (rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   bfsa_full_flags #(
      .NUM_WORDS   (NUM_WORDS),
      .AW          (AW),
      .PRESET_WORD (PRESET_WORD),
      .PRESET_FULL (PRESET_FULL)
   ) u_flags (
      .clock           (clock),
      .reset           (reset),
      .upd             (flag_upd),
      .upd_addr        (word_ff),
      .first_free_addr (first_free_addr),
      .any_free        (any_free)
   );

   // used count never exceeds the map size
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(MAP_BITS))
      else $error("used count above map size");

   // a word picked by find through the flags really holds a free bit
   a_find_consistent: assert property (@(posedge clock) disable iff (reset)
      (adv && (op_ff == OP_FIND) && hit_ff) |-> (free_bits != '0))
      else $error("full flags disagree with map word");

   // a transfer is followed by exactly one modify step before the next transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_MODIFY) && !req_ready)
      else $error("request taken while another is in flight");

   // no map write while idle
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_wr_en)
      else $error("memory written while idle");

   // a response never appears without a finished modify step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_MODIFY))
      else $error("response without modify step");

endmodule

### tb/tb_top.sv
// self-checking testbench of the bitmap free space allocator: directed and random requests
// keeps its own copy of the map and the used count; depends on bfsa_pkg and the top level
`timescale 1ns / 100ps

module tb_top;
   import bfsa_pkg::*;

   localparam int MAP_BITS     = DEF_MAP_BITS;
   localparam int PRESET_BIT   = DEF_PRESET_BIT;
   localparam int IDLE_PERCENT = 17;
   localparam int STALL_CYCLES = 250;
   localparam int WATCHDOG_MAX = 2000;

   // one expected response
   typedef struct packed {
      logic                   status;
      logic                   bit_value;
      logic [INDEX_WIDTH-1:0] free_index;
      logic [COUNT_WIDTH-1:0] used_count;
      logic [COUNT_WIDTH-1:0] free_count;
   } alloc_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [OP_WIDTH-1:0]    req_operation = '0;
   logic [INDEX_WIDTH-1:0] req_bit_pos = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_status;
   logic                   rsp_bit_value;
   logic [INDEX_WIDTH-1:0] rsp_free_index;
   logic [COUNT_WIDTH-1:0] rsp_used_count;
   logic [COUNT_WIDTH-1:0] rsp_free_count;

   // shadow of the map and its used count
   logic [MAP_BITS-1:0] shadow_map;
   int                  shadow_used;

   alloc_result_type pending_results[$];
   alloc_result_type oldest_result;
   int            error_count = 0;
   int            quiet_cycles = 0;
   int            stall_left = 0;
   logic          stall_request = 1'b0;
   logic          no_idle = 1'b0;

   bitmap_free_space_allocator dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_bit_pos    (req_bit_pos),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_bit_value  (rsp_bit_value),
      .rsp_free_index (rsp_free_index),
      .rsp_used_count (rsp_used_count),
      .rsp_free_count (rsp_free_count)
   );

   always #6 clock = ~clock;

   // expected response of one request, updating the shadow map
   function automatic alloc_result_type predict_alloc(input op_type op,
                                                      input logic [INDEX_WIDTH-1:0] idx);
      alloc_result_type r;
      logic             hit;
      r   = '0;
      hit = 1'b0;
      if (op == OP_FIND) begin
         // lowest clear bit, nothing claimed
         for (int i = 0; i < MAP_BITS; i++) begin
            if (!hit && !shadow_map[i]) begin
               hit          = 1'b1;
               r.free_index = INDEX_WIDTH'(i);
            end
         end
         r.status = hit ? STATUS_DONE : STATUS_NO_FREE;
      end else begin
         r.status    = STATUS_DONE;
         r.bit_value = shadow_map[idx];
         // count moves only when the bit flips
         if (op == OP_SET && !shadow_map[idx]) begin
            shadow_map[idx] = 1'b1;
            shadow_used++;
         end else if (op == OP_CLEAR && shadow_map[idx]) begin
            shadow_map[idx] = 1'b0;
            shadow_used--;
         end
      end
      r.used_count = COUNT_WIDTH'(shadow_used);
      r.free_count = COUNT_WIDTH'(MAP_BITS - shadow_used);
      return r;
   endfunction

   // one request transfer, with random idle cycles ahead of it
   task automatic send_request(input op_type op, input logic [INDEX_WIDTH-1:0] idx);
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_bit_pos   <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(predict_alloc(op, idx));
   endtask

   // sender stops until every response has come back
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_request();
      op_type                 op;
      logic [INDEX_WIDTH-1:0] idx;
      op = op_type'($urandom_range(3));
      // low indices half the time so finds land in the busy region
      if ($urandom_range(1) == 0)
         idx = INDEX_WIDTH'($urandom_range(63));
      else
         idx = INDEX_WIDTH'($urandom_range(MAP_BITS - 1));
      send_request(op, idx);
   endtask

   // preset bit, ends of the index range, repeated set and clear, empty map
   task automatic test_directed_cases();
      send_request(OP_TEST, INDEX_WIDTH'(PRESET_BIT));
      send_request(OP_FIND, '0);
      send_request(OP_TEST, '1);
      send_request(OP_SET, '1);
      send_request(OP_SET, '1);
      send_request(OP_TEST, '1);
      send_request(OP_CLEAR, '1);
      send_request(OP_CLEAR, '1);
      send_request(OP_CLEAR, INDEX_WIDTH'(PRESET_BIT));
      send_request(OP_FIND, '1);
      send_request(OP_SET, '0);
      send_request(OP_SET, 10'd1);
      send_request(OP_FIND, 10'h155);
      send_request(OP_SET, 10'd31);
      send_request(OP_SET, 10'd32);
      send_request(OP_TEST, 10'd32);
      send_request(OP_SET, 10'h2aa);
      send_request(OP_TEST, 10'h155);
      send_request(OP_TEST, 10'h200);
      send_request(OP_CLEAR, 10'd1);
      send_request(OP_FIND, '0);
      wait_for_responses();
   endtask

   task automatic test_random_mix(input int count);
      for (int k = 0; k < count; k++) send_random_request();
      wait_for_responses();
   endtask

   // long response stall while requests keep coming
   task automatic test_output_stall();
      no_idle       = 1'b1;
      stall_request = 1'b1;
      for (int k = 0; k < 30; k++) send_random_request();
      no_idle = 1'b0;
      wait_for_responses();
   endtask

   // set every bit in shuffled order until find reports no free bit
   task automatic test_fill_to_full();
      int order[MAP_BITS];
      int j;
      int tmp;
      for (int k = 0; k < MAP_BITS; k++) order[k] = k;
      for (int k = MAP_BITS - 1; k > 0; k--) begin
         j        = $urandom_range(k);
         tmp      = order[k];
         order[k] = order[j];
         order[j] = tmp;
      end
      // first part with no idle cycles on either side
      no_idle = 1'b1;
      for (int k = 0; k < MAP_BITS; k++) begin
         if (k == 300) no_idle = 1'b0;
         send_request(OP_SET, INDEX_WIDTH'(order[k]));
         if (k % 16 == 15) send_request(OP_FIND, INDEX_WIDTH'($urandom_range(MAP_BITS - 1)));
         if ($urandom_range(19) == 0)
            send_request(OP_TEST, INDEX_WIDTH'($urandom_range(MAP_BITS - 1)));
      end
      send_request(OP_FIND, '0);
      send_request(OP_SET, INDEX_WIDTH'($urandom_range(MAP_BITS - 1)));
      send_request(OP_FIND, '1);
      wait_for_responses();
   endtask

   // release bits from a full map and search again
   task automatic test_partial_release();
      for (int k = 0; k < 50; k++) begin
         send_request(OP_CLEAR, INDEX_WIDTH'($urandom_range(MAP_BITS - 1)));
         if ($urandom_range(3) == 0) send_request(OP_FIND, '0);
         if ($urandom_range(7) == 0)
            send_request(OP_TEST, INDEX_WIDTH'($urandom_range(MAP_BITS - 1)));
      end
      send_request(OP_FIND, '0);
      wait_for_responses();
   endtask

   // response ready: random idling, long stall on request
   always @(posedge clock) begin
      if (stall_request) begin
         stall_request = 1'b0;
         stall_left    = STALL_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (no_idle) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   task automatic check_field(input string name, input logic [COUNT_WIDTH-1:0] exp_v,
                              input logic [COUNT_WIDTH-1:0] got_v);
      if (exp_v != got_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
         error_count++;
      end
   endtask

   // compare each response transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: response with none expected, expected nothing, actual used %0d",
                     $time, rsp_used_count);
            error_count++;
         end else begin
            oldest_result = pending_results.pop_front();
            check_field("status", COUNT_WIDTH'(oldest_result.status),
                        COUNT_WIDTH'(rsp_status));
            check_field("bit_value", COUNT_WIDTH'(oldest_result.bit_value),
                        COUNT_WIDTH'(rsp_bit_value));
            check_field("free_index", COUNT_WIDTH'(oldest_result.free_index),
                        COUNT_WIDTH'(rsp_free_index));
            check_field("used_count", oldest_result.used_count, rsp_used_count);
            check_field("free_count", oldest_result.free_count, rsp_free_count);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      shadow_map             = '0;
      shadow_map[PRESET_BIT] = 1'b1;
      shadow_used            = 1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_mix(60);
      test_output_stall();
      test_fill_to_full();
      test_partial_release();
      test_random_mix(40);
      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         if (pending_results.size() != 0)
            $display("%0t: %0d responses never arrived, expected 0, actual %0d",
                     $time, pending_results.size(), pending_results.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
